// ----- rtl/strided_layout_index_mapper_core_defines.svh -----
// Assertion macros used by the strided layout index mapper core.
`ifndef STRIDED_LAYOUT_INDEX_MAPPER_CORE_DEFINES_SVH
`define STRIDED_LAYOUT_INDEX_MAPPER_CORE_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication, sampled on clk and held off during reset.
`define SLIM_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("slim assertion failed");
// Next-cycle implication, sampled on clk and held off during reset.
`define SLIM_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("slim assertion failed");
`else
`define SLIM_ASSERT_IMP(lbl, ante, cons)
`define SLIM_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/slim_pkg.sv -----
// Shared types, constants and the multiply-accumulate step of the layout mapper.
package slim_pkg;
	localparam int RANK_DEF = 4;
	localparam int RANK_MAX = 4;
	localparam int W = 64;
	localparam int VW = 63;

	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_INV = 2'd1;
	localparam logic [1:0] ST_DYN = 2'd2;
	localparam logic [1:0] ST_OVF = 2'd3;

	localparam logic [2:0] CFG_SHAPE_0  = 3'd0;
	localparam logic [2:0] CFG_SHAPE_1  = 3'd1;
	localparam logic [2:0] CFG_SHAPE_2  = 3'd2;
	localparam logic [2:0] CFG_SHAPE_3  = 3'd3;
	localparam logic [2:0] CFG_STRIDE_0 = 3'd4;
	localparam logic [2:0] CFG_STRIDE_1 = 3'd5;
	localparam logic [2:0] CFG_STRIDE_2 = 3'd6;
	localparam logic [2:0] CFG_STRIDE_3 = 3'd7;

	typedef logic [VW-1:0] slim_val_t;

	// One accumulation lane: running value plus a bit-serial product in flight.
	typedef struct packed {
		logic [1:0] st;
		logic       done;
		slim_val_t  val;
		slim_val_t  p;
		logic       ov;
	} slim_lane_t;

	typedef struct packed {
		logic                       req;
		logic [RANK_MAX-1:0][W-1:0] crd;
		logic [W-1:0]               idx;
		slim_lane_t                 il;
		slim_lane_t                 sl;
		slim_lane_t                 cl;
	} slim_mac_t;

	typedef struct packed {
		logic                        req;
		logic [1:0]                  st;
		slim_val_t                   index;
		slim_val_t                   size;
		logic [1:0]                  sst;
		slim_val_t                   cosize;
		logic [1:0]                  cst;
		logic [RANK_MAX-1:0][VW-1:0] dig;
		slim_val_t                   n;
		slim_val_t                   r;
	} slim_div_t;

	// One multiplier bit, most significant first: p = 2p + bit * x.
	// Any partial value above the signed 64-bit maximum sticks as overflow.
	function automatic slim_lane_t lane_step(slim_lane_t l, slim_val_t x, logic yb);
		slim_lane_t o;
		logic [VW+1:0] s;
		o = l;
		s = {1'b0, l.p, 1'b0} + (yb ? {2'b00, x} : '0);
		o.ov = l.ov | (s[VW+1:VW] != 2'b00);
		o.p = s[VW-1:0];
		return o;
	endfunction
endpackage

// ----- rtl/slim_mac_cell.sv -----
// One bit step of the three multiply-accumulate lanes for one dimension.
module slim_mac_cell #(
	parameter int DIM = 0,
	parameter int BIT = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_vld,
	input  slim_pkg::slim_mac_t in_dat,
	input  logic [63:0]         shape,
	input  logic [63:0]         stride,
	input  logic [63:0]         shm1,
	output logic                out_vld,
	output slim_pkg::slim_mac_t out_dat
);
	import slim_pkg::*;

	slim_mac_t nxt;
	logic      vld_s1;
	slim_mac_t dat_s1;

	always_comb begin
		nxt = in_dat;
		nxt.il = lane_step(in_dat.il, stride[VW-1:0], in_dat.crd[DIM][VW-1-BIT]);
		nxt.sl = lane_step(in_dat.sl, in_dat.sl.val, shape[VW-1-BIT]);
		nxt.cl = lane_step(in_dat.cl, stride[VW-1:0], shm1[VW-1-BIT]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dat_s1 <= nxt;
		end
	end

	assign out_vld = vld_s1;
	assign out_dat = dat_s1;
endmodule

// ----- rtl/slim_fin_cell.sv -----
// Closes one dimension: range and sign checks, final add and first-failure status.
module slim_fin_cell #(
	parameter int DIM = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_vld,
	input  slim_pkg::slim_mac_t in_dat,
	input  logic [63:0]         shape,
	input  logic [63:0]         stride,
	output logic                out_vld,
	output slim_pkg::slim_mac_t out_dat
);
	import slim_pkg::*;

	slim_mac_t  nxt;
	logic       shp_bad;
	logic       str_neg;
	logic       crd_bad;
	logic [W-1:0] isum;
	logic [W-1:0] csum;
	logic       vld_s1;
	slim_mac_t  dat_s1;

	always_comb begin
		shp_bad = shape[W-1] || (shape == '0);
		str_neg = stride[W-1];
		crd_bad = in_dat.crd[DIM][W-1] || ($signed(in_dat.crd[DIM]) >= $signed(shape));
		isum = {1'b0, in_dat.il.val} + {1'b0, in_dat.il.p};
		csum = {1'b0, in_dat.cl.val} + {1'b0, in_dat.cl.p};
		nxt = in_dat;

		if (!in_dat.il.done) begin
			if (shp_bad) begin
				nxt.il.st = ST_DYN;
				nxt.il.done = 1'b1;
			end else if (crd_bad || str_neg) begin
				nxt.il.st = ST_INV;
				nxt.il.done = 1'b1;
			end else if (in_dat.il.ov || isum[W-1]) begin
				nxt.il.st = ST_OVF;
				nxt.il.done = 1'b1;
			end else begin
				nxt.il.val = isum[VW-1:0];
			end
		end

		if (!in_dat.sl.done) begin
			if (shp_bad) begin
				nxt.sl.st = ST_DYN;
				nxt.sl.done = 1'b1;
			end else if (in_dat.sl.ov) begin
				nxt.sl.st = ST_OVF;
				nxt.sl.done = 1'b1;
			end else begin
				nxt.sl.val = in_dat.sl.p;
			end
		end

		if (!in_dat.cl.done) begin
			if (shp_bad) begin
				nxt.cl.st = ST_DYN;
				nxt.cl.done = 1'b1;
			end else if (str_neg) begin
				nxt.cl.st = ST_INV;
				nxt.cl.done = 1'b1;
			end else if (in_dat.cl.ov || csum[W-1]) begin
				nxt.cl.st = ST_OVF;
				nxt.cl.done = 1'b1;
			end else begin
				nxt.cl.val = csum[VW-1:0];
			end
		end

		// The next dimension starts its products from zero.
		nxt.il.p = '0;
		nxt.il.ov = 1'b0;
		nxt.sl.p = '0;
		nxt.sl.ov = 1'b0;
		nxt.cl.p = '0;
		nxt.cl.ov = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dat_s1 <= nxt;
		end
	end

	assign out_vld = vld_s1;
	assign out_dat = dat_s1;
endmodule

// ----- rtl/slim_div_cell.sv -----
// One restoring-division bit step; the last step of a dimension stores its mixed-radix digit.
module slim_div_cell #(
	parameter int DIM  = 0,
	parameter bit LAST = 1'b0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_vld,
	input  slim_pkg::slim_div_t in_dat,
	input  logic [63:0]         shape,
	output logic                out_vld,
	output slim_pkg::slim_div_t out_dat
);
	import slim_pkg::*;

	slim_div_t    nxt;
	logic [W-1:0] t;
	logic [W-1:0] diff;
	logic         ge;
	slim_val_t    rn;
	logic         vld_s1;
	slim_div_t    dat_s1;

	always_comb begin
		t = {in_dat.r, in_dat.n[VW-1]};
		diff = t - {1'b0, shape[VW-1:0]};
		ge = (t >= {1'b0, shape[VW-1:0]});
		rn = ge ? diff[VW-1:0] : t[VW-1:0];
		nxt = in_dat;
		// Quotient bits shift in where dividend bits shift out.
		nxt.n = {in_dat.n[VW-2:0], ge};
		if (LAST) begin
			nxt.dig[DIM] = rn;
			nxt.r = '0;
		end else begin
			nxt.r = rn;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dat_s1 <= nxt;
		end
	end

	assign out_vld = vld_s1;
	assign out_dat = dat_s1;
endmodule

// ----- rtl/strided_layout_index_mapper_core.sv -----
// Top level of the strided layout index mapper: config registers and the cell chain.
// Usage:
// Each input item (req_type, coord_in_*, index_in) gives exactly one result item.
// req_type 0 maps coordinates to a linear offset; req_type 1 splits index_in into
// per-dimension digits. Every result also carries layout size and cosize with status.
// Both channels use valid/stall; an item moves on an edge with valid high, stall low.
// Items flow through a chain of bit-serial cells: RANK*64 multiply-accumulate cells
// (63 bit steps and a closing cell per dimension), one check cell, then RANK*63
// restoring-division cells. A new item is taken every cycle unless in_stall is high.
// When out_valid is high and out_stall is asserted, the whole chain holds and
// in_stall is raised in the same cycle; nothing is dropped or repeated.
// Reset clears all stage valid bits, sets every shape to 1 and every stride to 0.
// Configuration must be written by the user through cfg_we/cfg_index/cfg_data
// while no items are in flight (not enforced); writes take effect on the next edge.
`include "strided_layout_index_mapper_core_defines.svh"
module strided_layout_index_mapper_core #(
	parameter int RANK = slim_pkg::RANK_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [63:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               req_type,
	input  logic signed [63:0] coord_in_0,
	input  logic signed [63:0] coord_in_1,
	input  logic signed [63:0] coord_in_2,
	input  logic signed [63:0] coord_in_3,
	input  logic signed [63:0] index_in,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic [62:0]        index_out,
	output logic [62:0]        coord_out_0,
	output logic [62:0]        coord_out_1,
	output logic [62:0]        coord_out_2,
	output logic [62:0]        coord_out_3,
	output logic [62:0]        size_out,
	output logic [1:0]         size_status,
	output logic [62:0]        cosize_out,
	output logic [1:0]         cosize_status
);
	import slim_pkg::*;

	localparam int MAC_LEN = RANK * (VW + 1);
	localparam int DIV_LEN = RANK * VW;

	logic [W-1:0] shape_q  [0:RANK_MAX-1];
	logic [W-1:0] stride_q [0:RANK_MAX-1];
	logic [W-1:0] shm1     [0:RANK_MAX-1];

	logic      en;
	logic      mac_vld [0:MAC_LEN];
	slim_mac_t mac_dat [0:MAC_LEN];
	logic      div_vld [0:DIV_LEN];
	slim_div_t div_dat [0:DIV_LEN];

	slim_mac_t chk_in;
	slim_div_t chk_nxt;
	logic      chk_vld_s1;
	slim_div_t chk_dat_s1;
	slim_div_t fin;
	logic      dig_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < RANK_MAX; i++) begin
				shape_q[i] <= 64'd1;
				stride_q[i] <= '0;
			end
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SHAPE_0: begin
					shape_q[0] <= cfg_data;
				end
				CFG_SHAPE_1: begin
					shape_q[1] <= cfg_data;
				end
				CFG_SHAPE_2: begin
					shape_q[2] <= cfg_data;
				end
				CFG_SHAPE_3: begin
					shape_q[3] <= cfg_data;
				end
				CFG_STRIDE_0: begin
					stride_q[0] <= cfg_data;
				end
				CFG_STRIDE_1: begin
					stride_q[1] <= cfg_data;
				end
				CFG_STRIDE_2: begin
					stride_q[2] <= cfg_data;
				end
				CFG_STRIDE_3: begin
					stride_q[3] <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		for (int i = 0; i < RANK_MAX; i++) begin
			shm1[i] = shape_q[i] - 64'd1;
		end
	end

	// The whole chain advances unless a finished result is held by the receiver.
	assign in_stall = out_valid && out_stall;
	assign en = !in_stall;

	always_comb begin
		mac_dat[0] = '0;
		mac_dat[0].req = req_type;
		mac_dat[0].crd[0] = coord_in_0;
		mac_dat[0].crd[1] = coord_in_1;
		mac_dat[0].crd[2] = coord_in_2;
		mac_dat[0].crd[3] = coord_in_3;
		mac_dat[0].idx = index_in;
		mac_dat[0].sl.val = 63'd1;
		mac_dat[0].cl.val = 63'd1;
	end
	assign mac_vld[0] = in_valid;

	for (genvar d = 0; d < RANK; d++) begin : g_dim
		for (genvar b = 0; b < VW; b++) begin : g_bit
			slim_mac_cell #(
				.DIM(d),
				.BIT(b)
			) u_mac (
				.clk    (clk),
				.arst_n (arst_n),
				.en     (en),
				.in_vld (mac_vld[d*(VW+1)+b]),
				.in_dat (mac_dat[d*(VW+1)+b]),
				.shape  (shape_q[d]),
				.stride (stride_q[d]),
				.shm1   (shm1[d]),
				.out_vld(mac_vld[d*(VW+1)+b+1]),
				.out_dat(mac_dat[d*(VW+1)+b+1])
			);
		end
		slim_fin_cell #(
			.DIM(d)
		) u_fin (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.in_vld (mac_vld[d*(VW+1)+VW]),
			.in_dat (mac_dat[d*(VW+1)+VW]),
			.shape  (shape_q[d]),
			.stride (stride_q[d]),
			.out_vld(mac_vld[(d+1)*(VW+1)]),
			.out_dat(mac_dat[(d+1)*(VW+1)])
		);
	end

	// Check cell: settles size, cosize and the request status, seeds the divider.
	always_comb begin
		chk_in = mac_dat[MAC_LEN];
		chk_nxt = '0;
		chk_nxt.req = chk_in.req;
		chk_nxt.sst = chk_in.sl.st;
		chk_nxt.cst = chk_in.cl.st;
		chk_nxt.size = (chk_in.sl.st == ST_OK) ? chk_in.sl.val : '0;
		chk_nxt.cosize = (chk_in.cl.st == ST_OK) ? chk_in.cl.val : '0;
		chk_nxt.n = chk_in.idx[VW-1:0];
		if (chk_in.req) begin
			if (chk_in.idx[W-1]) begin
				chk_nxt.st = ST_INV;
			end else if (chk_in.sl.st != ST_OK) begin
				chk_nxt.st = chk_in.sl.st;
			end else if (chk_in.idx[VW-1:0] >= chk_in.sl.val) begin
				chk_nxt.st = ST_INV;
			end else begin
				chk_nxt.st = ST_OK;
			end
		end else begin
			chk_nxt.st = chk_in.il.st;
			chk_nxt.index = (chk_in.il.st == ST_OK) ? chk_in.il.val : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chk_vld_s1 <= 1'b0;
		end else if (en) begin
			chk_vld_s1 <= mac_vld[MAC_LEN];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			chk_dat_s1 <= chk_nxt;
		end
	end

	assign div_vld[0] = chk_vld_s1;
	assign div_dat[0] = chk_dat_s1;

	for (genvar d = 0; d < RANK; d++) begin : g_ddim
		for (genvar b = 0; b < VW; b++) begin : g_dbit
			slim_div_cell #(
				.DIM (d),
				.LAST(b == VW - 1)
			) u_div (
				.clk    (clk),
				.arst_n (arst_n),
				.en     (en),
				.in_vld (div_vld[d*VW+b]),
				.in_dat (div_dat[d*VW+b]),
				.shape  (shape_q[d]),
				.out_vld(div_vld[d*VW+b+1]),
				.out_dat(div_dat[d*VW+b+1])
			);
		end
	end

	assign fin = div_dat[DIV_LEN];
	assign dig_ok = fin.req && (fin.st == ST_OK);

	assign out_valid = div_vld[DIV_LEN];
	assign status = fin.st;
	assign index_out = fin.index;
	assign coord_out_0 = dig_ok ? fin.dig[0] : '0;
	assign coord_out_1 = dig_ok ? fin.dig[1] : '0;
	assign coord_out_2 = dig_ok ? fin.dig[2] : '0;
	assign coord_out_3 = dig_ok ? fin.dig[3] : '0;
	assign size_out = fin.size;
	assign size_status = fin.sst;
	assign cosize_out = fin.cosize;
	assign cosize_status = fin.cst;

	`SLIM_ASSERT_IMP(a_err_zero, out_valid && status != ST_OK, index_out == '0 && coord_out_0 == '0)
	`SLIM_ASSERT_IMP(a_size_ok, out_valid, (size_status == ST_OK) == (size_out != '0))
	`SLIM_ASSERT_IMP(a_cosize_ok, out_valid, (cosize_status == ST_OK) == (cosize_out != '0))
	`SLIM_ASSERT_IMP(a_size_st, out_valid, size_status != ST_INV)
	`SLIM_ASSERT_NXT(a_chk_hold, !en, $stable(chk_vld_s1))
endmodule

// ----- dv/tb_strided_layout_index_mapper_core.sv -----
// Self-checking testbench for the strided layout index mapper core.
`timescale 1ns / 1ps
module tb_strided_layout_index_mapper_core;
	import slim_pkg::*;

	localparam longint MAXV = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam int LATENCY = 4 * 127 + 1;

	typedef struct {
		logic [1:0]  st;
		logic [62:0] index;
		logic [62:0] dig [4];
		logic [62:0] size;
		logic [1:0]  sst;
		logic [62:0] cosize;
		logic [1:0]  cst;
	} mapping_t;

	typedef struct {
		logic        rt;
		longint      crd [4];
		longint      idx;
		logic        known;
		logic [1:0]  st;
		logic [62:0] index;
	} req_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [63:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic req_type = 1'b0;
	logic signed [63:0] coord_in_0 = '0, coord_in_1 = '0, coord_in_2 = '0, coord_in_3 = '0;
	logic signed [63:0] index_in = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] status, size_status, cosize_status;
	logic [62:0] index_out, coord_out_0, coord_out_1, coord_out_2, coord_out_3;
	logic [62:0] size_out, cosize_out;

	longint layout_shape [4];
	longint layout_stride [4];
	mapping_t pending_maps [$];
	int errors = 0;
	bit hold_off = 1'b0;
	bit rx_quiet = 1'b0;

	strided_layout_index_mapper_core DUT (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic mapping_t map_request(logic rt, longint crd [4], longint idx);
		mapping_t m;
		longint total, span, acc, rem, sz;
		int i;
		m.st = ST_OK; m.index = '0; m.size = '0; m.cosize = '0;
		m.sst = ST_OK; m.cst = ST_OK;
		for (i = 0; i < 4; i++) m.dig[i] = '0;
		total = 1;
		for (i = 0; i < 4; i++) begin
			if (layout_shape[i] <= 0) begin m.sst = ST_DYN; break; end
			if (total > MAXV / layout_shape[i]) begin m.sst = ST_OVF; break; end
			total *= layout_shape[i];
		end
		sz = (m.sst == ST_OK) ? total : 0;
		m.size = sz[62:0];
		span = 1;
		for (i = 0; i < 4; i++) begin
			if (layout_shape[i] <= 0) begin m.cst = ST_DYN; break; end
			if (layout_stride[i] < 0) begin m.cst = ST_INV; break; end
			if (layout_shape[i] > 1 &&
					layout_stride[i] > (MAXV - span) / (layout_shape[i] - 1)) begin
				m.cst = ST_OVF; break;
			end
			span += (layout_shape[i] - 1) * layout_stride[i];
		end
		if (m.cst == ST_OK) m.cosize = span[62:0];
		if (!rt) begin
			acc = 0;
			for (i = 0; i < 4; i++) begin
				if (layout_shape[i] <= 0) begin m.st = ST_DYN; break; end
				if (crd[i] < 0 || crd[i] >= layout_shape[i] || layout_stride[i] < 0) begin
					m.st = ST_INV; break;
				end
				if (crd[i] != 0 && layout_stride[i] > (MAXV - acc) / crd[i]) begin
					m.st = ST_OVF; break;
				end
				acc += crd[i] * layout_stride[i];
			end
			if (m.st == ST_OK) m.index = acc[62:0];
		end else begin
			rem = idx;
			if (rem < 0) m.st = ST_INV;
			else if (m.sst != ST_OK) m.st = m.sst;
			else if (rem >= sz) m.st = ST_INV;
			else begin
				for (i = 0; i < 4; i++) begin
					m.dig[i] = 63'(rem % layout_shape[i]);
					rem = rem / layout_shape[i];
				end
			end
		end
		return m;
	endfunction

	task automatic write_reg(logic [2:0] r, longint v);
		@(negedge clk);
		cfg_we <= 1'b1; cfg_index <= r; cfg_data <= v;
		if (r < CFG_STRIDE_0) layout_shape[r[1:0]] = v;
		else layout_stride[r[1:0]] = v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_layout(longint s0, s1, s2, s3, t0, t1, t2, t3);
		write_reg(CFG_SHAPE_0, s0); write_reg(CFG_SHAPE_1, s1);
		write_reg(CFG_SHAPE_2, s2); write_reg(CFG_SHAPE_3, s3);
		write_reg(CFG_STRIDE_0, t0); write_reg(CFG_STRIDE_1, t1);
		write_reg(CFG_STRIDE_2, t2); write_reg(CFG_STRIDE_3, t3);
	endtask

	// Drops the input valid and waits until every expected result has come.
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending_maps.size() != 0) @(negedge clk);
	endtask

	// Called at a falling edge; returns at the falling edge after acceptance.
	// The valid stays high on return so that items can follow with no gap.
	task automatic send_request(logic rt, longint crd [4], longint idx);
		int gap;
		gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_type <= rt;
		coord_in_0 <= crd[0]; coord_in_1 <= crd[1]; coord_in_2 <= crd[2]; coord_in_3 <= crd[3];
		index_in <= idx;
		in_valid <= 1'b1;
		pending_maps.insert(pending_maps.size(), map_request(rt, crd, idx));
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	function automatic longint pick_value(longint ext);
		case ($urandom_range(0, 9))
			0: return -longint'($urandom_range(1, 5));
			1: return ext;
			2: return {$urandom, $urandom};
			3: return 0;
			default: return (ext > 0) ? longint'($urandom_range(0, 1000)) % ext : 0;
		endcase
	endfunction

	function automatic longint pick_shape();
		case ($urandom_range(0, 11))
			0: return -1;
			1: return 0;
			2: return MAXV;
			3: return {1'b0, 31'($urandom), $urandom};
			default: return longint'($urandom_range(1, 12));
		endcase
	endfunction

	function automatic longint pick_stride();
		case ($urandom_range(0, 11))
			0: return -longint'($urandom_range(1, 3));
			1: return 64'sh8000_0000_0000_0000;
			2: return MAXV;
			3: return {1'b0, 31'($urandom), $urandom};
			default: return longint'($urandom_range(0, 200));
		endcase
	endfunction

	// Receiver: random stalls plus one long hold-off on request.
	initial begin
		int gap;
		forever begin
			@(negedge clk);
			if (hold_off) begin
				out_stall <= 1'b1;
				repeat (2 * LATENCY) @(negedge clk);
				out_stall <= 1'b0;
				hold_off = 1'b0;
			end else begin
				if (rx_quiet) gap = 0;
				else gap = ($urandom_range(0, 15) == 0) ? $urandom_range(4, 40)
					: $urandom_range(0, 1);
				if (gap != 0) begin
					out_stall <= 1'b1;
					repeat (gap) @(negedge clk);
					out_stall <= 1'b0;
				end
				repeat ($urandom_range(0, 20)) @(negedge clk);
			end
		end
	end

	always @(posedge clk) begin
		mapping_t m;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_maps.size() == 0) begin
				$error("unexpected result item");
				errors++;
			end else begin
				m = pending_maps.pop_front();
				if (status !== m.st) begin
					$error("status exp %0d got %0d", m.st, status); errors++;
				end
				if (index_out !== m.index) begin
					$error("index_out exp %0d got %0d", m.index, index_out); errors++;
				end
				if (coord_out_0 !== m.dig[0]) begin
					$error("coord_out_0 exp %0d got %0d", m.dig[0], coord_out_0); errors++;
				end
				if (coord_out_1 !== m.dig[1]) begin
					$error("coord_out_1 exp %0d got %0d", m.dig[1], coord_out_1); errors++;
				end
				if (coord_out_2 !== m.dig[2]) begin
					$error("coord_out_2 exp %0d got %0d", m.dig[2], coord_out_2); errors++;
				end
				if (coord_out_3 !== m.dig[3]) begin
					$error("coord_out_3 exp %0d got %0d", m.dig[3], coord_out_3); errors++;
				end
				if (size_out !== m.size) begin
					$error("size_out exp %0d got %0d", m.size, size_out); errors++;
				end
				if (size_status !== m.sst) begin
					$error("size_status exp %0d got %0d", m.sst, size_status); errors++;
				end
				if (cosize_out !== m.cosize) begin
					$error("cosize_out exp %0d got %0d", m.cosize, cosize_out); errors++;
				end
				if (cosize_status !== m.cst) begin
					$error("cosize_status exp %0d got %0d", m.cst, cosize_status); errors++;
				end
			end
		end
	end

	initial begin
		req_row_t rows [$];
		req_row_t r;
		longint crd [4];
		mapping_t m;
		int i, n, d;

		for (i = 0; i < 4; i++) begin layout_shape[i] = 1; layout_stride[i] = 0; end
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset layout: size 1, cosize 1, only the all-zero coordinate is legal.
		r.rt = 0; r.crd = '{0, 0, 0, 0}; r.idx = 0; r.known = 1; r.st = ST_OK; r.index = 0;
		rows.insert(rows.size(), r);
		r.crd = '{1, 0, 0, 0}; r.st = ST_INV; rows.insert(rows.size(), r);
		r.crd = '{0, 0, 0, -1}; rows.insert(rows.size(), r);
		r.rt = 1; r.crd = '{0, 0, 0, 0}; r.idx = -1; rows.insert(rows.size(), r);
		r.idx = 1; rows.insert(rows.size(), r);
		r.idx = 0; r.st = ST_OK; rows.insert(rows.size(), r);
		r.idx = 64'sh8000_0000_0000_0000; r.st = ST_INV; rows.insert(rows.size(), r);
		foreach (rows[k]) begin
			m = map_request(rows[k].rt, rows[k].crd, rows[k].idx);
			if (rows[k].known && m.st !== rows[k].st) begin
				$error("status exp %0d got %0d", rows[k].st, m.st); errors++;
			end
			if (rows[k].known && m.index !== rows[k].index) begin
				$error("index_out exp %0d got %0d", rows[k].index, m.index); errors++;
			end
			send_request(rows[k].rt, rows[k].crd, rows[k].idx);
		end
		wait_drained();
		repeat (LATENCY) @(negedge clk);

		// Directed layouts: ordinary, size overflow, stride overflow, bad stride, dynamic.
		set_layout(3, 4, 5, 6, 1, 3, 12, 60);
		crd = '{2, 3, 4, 5}; send_request(0, crd, 0);
		crd = '{3, 0, 0, 0}; send_request(0, crd, 0);
		send_request(1, crd, 359);
		send_request(1, crd, 360);
		send_request(1, crd, 137);
		wait_drained();
		set_layout(MAXV, 2, 1, 1, 1, MAXV, 0, 0);
		crd = '{0, 1, 0, 0}; send_request(0, crd, 0);
		crd = '{MAXV - 1, 0, 0, 0}; send_request(0, crd, 0);
		send_request(1, crd, 5);
		wait_drained();
		set_layout(2, 2, 2, 2, 1, 64'sh8000_0000_0000_0000, 1, 1);
		crd = '{1, 1, 1, 1}; send_request(0, crd, 0);
		crd = '{1, 0, 1, 1}; send_request(0, crd, 0);
		send_request(1, crd, 15);
		wait_drained();
		set_layout(4, 0, -1, 4, 1, 1, 1, 1);
		crd = '{1, 0, 0, 0}; send_request(0, crd, 0);
		send_request(1, crd, 2);
		wait_drained();
		repeat (LATENCY) @(negedge clk);

		// Random phases: new layout each, long hold-off in one, drain pause in another.
		for (n = 0; n < 11; n++) begin
			set_layout(pick_shape(), pick_shape(), pick_shape(), pick_shape(),
				pick_stride(), pick_stride(), pick_stride(), pick_stride());
			if (n == 2) hold_off = 1'b1;
			rx_quiet = (n == 5);
			for (i = 0; i < 50; i++) begin
				for (d = 0; d < 4; d++) crd[d] = pick_value(layout_shape[d]);
				if (i == 25 && n == 4) wait_drained();
				// During the hold-off, resume once the first items reach the output,
				// so that the remaining items meet a full chain.
				if (i == 10 && n == 2) begin
					in_valid <= 1'b0;
					repeat (LATENCY) @(negedge clk);
				end
				send_request(1'($urandom_range(0, 1)), crd,
					($urandom_range(0, 3) == 0) ? longint'({$urandom, $urandom})
					: longint'($urandom_range(0, 3000)));
			end
			wait_drained();
			repeat (LATENCY) @(negedge clk);
		end
		repeat (LATENCY + 20) @(negedge clk);
		if (errors == 0 && pending_maps.size() == 0)
			$display("strided_layout_index_mapper_core: match");
		else
			$display("strided_layout_index_mapper_core: mismatch");
		$finish;
	end

	initial begin
		#4000000;
		$display("strided_layout_index_mapper_core: mismatch");
		$finish;
	end
endmodule
